// ===== rtl/core/joint_velocity_estimator_assert.svh =====
// Assertion macros shared by the joint velocity estimator RTL.
// Define ASSERT_OFF to compile all checks away.
`ifndef JOINT_VELOCITY_ESTIMATOR_ASSERT_SVH
`define JOINT_VELOCITY_ESTIMATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define JVE_ASSERT_IMPL(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define JVE_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define JVE_ASSERT_IMPL(label, prop, msg)
`define JVE_ASSERT_RST(label, prop, msg)
`endif
`endif

// ===== rtl/core/jve_pkg.sv =====
// Shared types and constants for the joint velocity estimator.
// No dependencies.
`default_nettype none
package jve_pkg;
  localparam int REG_MEASURED_MODE = 0;
  localparam int REG_WINDOW_LENGTH = 1;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 6;
  localparam logic [29:0] NS_PER_SECOND = 30'd1000000000;

  // One classified item passed from front to back
  typedef struct packed {
    logic [2:0]  joint;
    logic        warm;      // first sample: emit zero, warming_up
    logic        use_meas;  // raw velocity is the measured value
    logic [31:0] meas;
    logic signed [20:0] dpos;
    logic [47:0] dt;
  } task_t;

  // Result item
  typedef struct packed {
    logic        warming_up;
    logic [31:0] velocity;
    logic [2:0]  joint;
  } result_t;
endpackage
`default_nettype wire

// ===== rtl/core/joint_velocity_estimator.sv =====
// Top level of the joint velocity estimator: config registers, front, queue, back.
// Depends on jve_pkg, jve_front, jve_back.
//
//  channel   | direction | payload
//  s_axis    | in        | tdata: joint, position, stamp_ns, measured_velocity
//            |           | tuser: velocity_present
//  m_axis    | out       | tdata: joint_out, smoothed_velocity; tuser: warming_up
//  cfg       | in        | wr_en, wr_index, wr_data
//
// A differenced item passes from acceptance to result through the front register, two
// divisions in the shared iterative divider and six sequencing steps. A measured
// velocity skips the difference division; a first sample gets its result without any division.
// Rejected samples (bad interval or joint) are absorbed without a result.
// Reset is synchronous and clears all per-joint control state at once; no clearing pass.
// The front register lets one item wait while the back end works and its result stalls.
`default_nettype none
module joint_velocity_estimator #(
  parameter int MAX_WINDOW  = 50,
  parameter int JOINT_COUNT = 6
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // joint[2:0], position[22:3], stamp_ns[70:23], measured_velocity[102:71],
  // zero fill to 104
  input  wire logic [103:0] s_axis_tdata,
  // velocity_present[0]
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // joint_out[2:0], smoothed_velocity[34:3], zero fill to 40
  output logic [39:0]       m_axis_tdata,
  // warming_up[0]
  output logic              m_axis_tuser,
  input  wire logic         wr_en,
  input  wire logic [jve_pkg::CFG_INDEX_W-1:0] wr_index,
  input  wire logic [jve_pkg::CFG_DATA_W-1:0]  wr_data
);
  import jve_pkg::*;
  logic measured_mode;
  logic [5:0] window_length;
  logic clear_avg;
  logic q_valid, q_ready;
  task_t q_task;
  result_t res;

  // Configuration registers
  assign clear_avg = wr_en && (wr_index == CFG_INDEX_W'(REG_WINDOW_LENGTH));
  always_ff @(posedge clk) begin
    if (rst) begin
      measured_mode <= 1'b0;
      window_length <= 6'd50;
    end else if (wr_en) begin
      if (wr_index == CFG_INDEX_W'(REG_MEASURED_MODE)) measured_mode <= wr_data[0];
      else window_length <= wr_data;
    end
  end

  jve_front #(.JOINT_COUNT(JOINT_COUNT)) u_front (
    .clk(clk), .rst(rst), .measured_mode(measured_mode),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .joint(s_axis_tdata[2:0]), .position(s_axis_tdata[22:3]),
    .stamp_ns(s_axis_tdata[70:23]), .measured_velocity(s_axis_tdata[102:71]),
    .velocity_present(s_axis_tuser),
    .q_valid(q_valid), .q_ready(q_ready), .q_task(q_task)
  );

  jve_back #(.MAX_WINDOW(MAX_WINDOW), .JOINT_COUNT(JOINT_COUNT)) u_back (
    .clk(clk), .rst(rst), .window_length(window_length), .clear_avg(clear_avg),
    .q_valid(q_valid), .q_ready(q_ready), .q_task(q_task),
    .m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .m_res(res)
  );

  assign m_axis_tdata = {5'd0, res.velocity, res.joint};
  assign m_axis_tuser = res.warming_up;
endmodule
`default_nettype wire

// ===== rtl/core/jve_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module jve_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 300
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/jve_divider.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on nothing beyond its parameters.
`default_nettype none
module jve_divider #(
  parameter int NW = 64,
  parameter int DW = 48
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,      // two's complement
  input  wire logic [DW-1:0] den,      // positive magnitude
  output logic               busy,
  output logic               done,
  output logic [NW-1:0]      quo       // two's complement
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] rem_q;
  logic [DW:0]   part;
  logic [DW-1:0] den_q;
  logic          neg;
  logic [CW-1:0] count;
  logic [DW:0]   trial;
  logic [DW:0]   shifted;

  assign shifted = {part[DW-1:0], rem_q[NW-1]};
  assign trial = shifted - {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // done pulses after the last quotient bit
      done <= busy && (count == CW'(1));
      if (start && !busy) begin
        busy  <= 1'b1;
        neg   <= num[NW-1];
        rem_q <= num[NW-1] ? (~num + 1'b1) : num;
        den_q <= den;
        part  <= '0;
        count <= CW'(NW);
      end else if (busy) begin
        if (!trial[DW]) begin
          part <= trial;
          rem_q <= {rem_q[NW-2:0], 1'b1};
        end else begin
          part <= shifted;
          rem_q <= {rem_q[NW-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end
  assign quo = neg ? (~rem_q + 1'b1) : rem_q;
endmodule
`default_nettype wire

// ===== rtl/core/jve_front.sv =====
// Front end: accepts samples, keeps per-joint previous sample, classifies items.
// Depends on jve_pkg.
`default_nettype none
module jve_front #(
  parameter int JOINT_COUNT = 6
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   measured_mode,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire logic [2:0]  joint,
  input  wire logic [19:0] position,
  input  wire logic [47:0] stamp_ns,
  input  wire logic [31:0] measured_velocity,
  input  wire logic        velocity_present,
  output logic        q_valid,
  input  wire logic   q_ready,
  output jve_pkg::task_t q_task
);
  import jve_pkg::*;
  logic [JOINT_COUNT-1:0] prev_valid;
  logic [19:0] prev_position [JOINT_COUNT];
  logic [47:0] prev_stamp [JOINT_COUNT];
  logic in_range, use_meas, warm, bad_dt;
  logic [$clog2(JOINT_COUNT+1)-1:0] jidx;

  // Single-entry output register toward the queue
  assign in_ready = !q_valid || q_ready;
  assign jidx = ($clog2(JOINT_COUNT+1))'(joint);
  assign in_range = jidx < ($clog2(JOINT_COUNT+1))'(JOINT_COUNT);
  assign use_meas = measured_mode && velocity_present;
  assign warm = !use_meas && !prev_valid[jidx[$clog2(JOINT_COUNT)-1+($clog2(JOINT_COUNT)==0):0]];
  assign bad_dt = !use_meas && !warm &&
    (stamp_ns <= prev_stamp[jidx[$clog2(JOINT_COUNT)-1+($clog2(JOINT_COUNT)==0):0]]);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
      prev_valid <= '0;
    end else begin
      if (in_valid && in_ready && in_range && !bad_dt) begin
        q_valid <= 1'b1;
        q_task.joint <= joint;
        q_task.warm <= warm;
        q_task.use_meas <= use_meas;
        q_task.meas <= measured_velocity;
        q_task.dpos <= $signed({position[19], position}) -
          $signed({prev_position[jidx[$clog2(JOINT_COUNT)-1+($clog2(JOINT_COUNT)==0):0]][19],
                   prev_position[jidx[$clog2(JOINT_COUNT)-1+($clog2(JOINT_COUNT)==0):0]]});
        q_task.dt <= stamp_ns - prev_stamp[jidx[$clog2(JOINT_COUNT)-1+($clog2(JOINT_COUNT)==0):0]];
        if (use_meas) begin
          prev_valid[jidx[$clog2(JOINT_COUNT)-1+($clog2(JOINT_COUNT)==0):0]] <= 1'b0;
        end else begin
          prev_valid[jidx[$clog2(JOINT_COUNT)-1+($clog2(JOINT_COUNT)==0):0]] <= 1'b1;
          prev_position[jidx[$clog2(JOINT_COUNT)-1+($clog2(JOINT_COUNT)==0):0]] <= position;
          prev_stamp[jidx[$clog2(JOINT_COUNT)-1+($clog2(JOINT_COUNT)==0):0]] <= stamp_ns;
        end
      end else if (q_valid && q_ready) begin
        q_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/jve_back.sv =====
// Back end: differencing division, ring history, running sum and average division.
// Depends on jve_pkg, jve_divider, jve_ram and the assertion header.
`default_nettype none
`include "joint_velocity_estimator_assert.svh"
module jve_back #(
  parameter int MAX_WINDOW  = 50,
  parameter int JOINT_COUNT = 6
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic [5:0] window_length,
  input  wire logic   clear_avg,
  input  wire logic   q_valid,
  output logic        q_ready,
  input  wire jve_pkg::task_t q_task,
  output logic        m_valid,
  input  wire logic   m_ready,
  output jve_pkg::result_t m_res
);
  import jve_pkg::*;
  localparam int DEPTH = MAX_WINDOW * JOINT_COUNT;
  localparam int AW = $clog2(DEPTH);
  localparam int SW = $clog2(MAX_WINDOW + 1);
  localparam int JW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
  localparam int SUMW = 32 + SW;

  localparam logic [2:0] S_IDLE = 3'd0, S_DIFF = 3'd1, S_READ = 3'd2,
                         S_UPD = 3'd3, S_AVG = 3'd4, S_OUT = 3'd5;
  logic [2:0] state;
  task_t cur;
  logic [31:0] raw;
  logic [SW-1:0] fill_count [JOINT_COUNT];
  logic [SW-1:0] write_slot [JOINT_COUNT];
  logic signed [SUMW-1:0] running_sum [JOINT_COUNT];
  logic [SW-1:0] win, slot, slot_inc;
  logic [JW-1:0] j;
  logic [AW-1:0] addr;
  logic [31:0] old_val;
  logic full;
  logic div_start, div_busy, div_done;
  logic [63:0] div_num, div_quo;
  logic [47:0] div_den;
  logic [63:0] prod;
  logic signed [SUMW-1:0] new_sum;
  logic [SW-1:0] new_fill;
  logic [31:0] sat_q;
  logic out_step;

  // Effective window: 0 acts as 1, above MAX_WINDOW clamps
  always_comb begin
    if (window_length == 6'd0) win = SW'(1);
    else if (32'(window_length) > 32'(MAX_WINDOW)) win = SW'(MAX_WINDOW);
    else win = SW'(window_length);
  end
  assign j = JW'(cur.joint);
  assign slot = (write_slot[j] >= win) ? '0 : write_slot[j];
  assign slot_inc = (slot + 1'b1 >= win) ? '0 : slot + 1'b1;
  assign addr = AW'(32'(j) * MAX_WINDOW + 32'(slot));
  assign full = fill_count[j] >= win;

  // Difference division starts as the item is taken, so it reads the incoming item
  // dpos is at most 21 bits, times 1e9 fits in 51 bits
  assign prod = 64'($signed(q_task.dpos) * $signed({1'b0, NS_PER_SECOND}));
  assign div_num = (state == S_IDLE) ? prod : {{(64-SUMW){new_sum[SUMW-1]}}, new_sum};
  assign div_den = (state == S_IDLE) ? q_task.dt : 48'(new_fill);

  // Saturate signed 64-bit quotient to 32 bits
  always_comb begin
    if ($signed(div_quo) > 64'sd2147483647) sat_q = 32'h7fffffff;
    else if ($signed(div_quo) < -64'sd2147483648) sat_q = 32'h80000000;
    else sat_q = div_quo[31:0];
  end

  jve_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_hist (
    .clk(clk), .we(state == S_UPD), .waddr(addr), .wdata(raw),
    .raddr(addr), .rdata(old_val)
  );

  jve_divider #(.NW(64), .DW(48)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .done(div_done), .quo(div_quo)
  );

  assign q_ready = (state == S_IDLE) && !m_valid;
  assign div_start = (state == S_UPD) || (state == S_IDLE && q_valid && q_ready &&
                     !q_task.warm && !q_task.use_meas);
  assign new_fill = full ? fill_count[j] : fill_count[j] + 1'b1;
  assign new_sum = running_sum[j] - (full ? SUMW'($signed(old_val)) : '0) +
                   SUMW'($signed(raw));
  assign out_step = (state == S_IDLE) || (state == S_OUT);

  // Sequencer for one item
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_valid <= 1'b0;
      for (int k = 0; k < JOINT_COUNT; k++) begin
        fill_count[k] <= '0;
        write_slot[k] <= '0;
        running_sum[k] <= '0;
      end
    end else begin
      if (m_valid && m_ready) m_valid <= 1'b0;
      if (clear_avg) begin
        for (int k = 0; k < JOINT_COUNT; k++) begin
          fill_count[k] <= '0;
          write_slot[k] <= '0;
          running_sum[k] <= '0;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            cur <= q_task;
            raw <= q_task.meas;
            if (q_task.warm) begin
              m_valid <= 1'b1;
              m_res <= '{warming_up: 1'b1, velocity: 32'd0, joint: q_task.joint};
            end else if (q_task.use_meas) state <= S_READ;
            else state <= S_DIFF;
          end
        end
        S_DIFF: if (div_done) begin
          raw <= sat_q;
          state <= S_READ;
        end
        S_READ: state <= S_UPD;
        S_UPD: begin
          fill_count[j] <= new_fill;
          running_sum[j] <= new_sum;
          write_slot[j] <= slot_inc;
          state <= S_AVG;
        end
        S_AVG: if (div_done) begin
          m_res <= '{warming_up: 1'b0, velocity: sat_q, joint: cur.joint};
          state <= S_OUT;
        end
        S_OUT: begin
          m_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The shared divider is only started when free
  `JVE_ASSERT_IMPL(a_div_free, div_start |-> !div_busy, "divider started while busy")
  // A result is only loaded in the idle or output step
  `JVE_ASSERT_IMPL(a_out_state, $rose(m_valid) |-> $past(out_step), "result out of sequence")
  // No item is taken while a result waits
  `JVE_ASSERT_RST(a_no_take, q_ready |-> !m_valid, "item taken over pending result")
endmodule
`default_nettype wire
